// ===== rtl/ucrh_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the unit-cylinder ray hit pipeline.
package ucrh_pkg;

   typedef struct packed {
      logic signed [47:0] origin_x;
      logic signed [47:0] origin_y;
      logic signed [47:0] origin_z;
      logic signed [47:0] dir_x;
      logic signed [47:0] dir_y;
      logic signed [47:0] dir_z;
      logic [46:0]        distance_scale;
   } req_type;

   typedef struct packed {
      logic        hit_found;
      logic [46:0] hit_distance;
   } rsp_type;

   // a < 1e-6 in Q.64
   localparam logic [95:0] A_MIN = 96'd18446744073710;
   // t > 1e-6 in Q.32
   localparam logic [86:0] T_MIN = 87'd4295;
   localparam logic [46:0] DIST_MAX = {47{1'b1}};

endpackage

// ===== rtl/unit_cylinder_ray_hit.sv =====
`timescale 1ns / 1ps
// Unit-cylinder ray hit: top level of the ray/side-wall intersection pipeline.
// Takes one request per clock whenever busy is low; busy is high only during
// reset and the cycle after. Every request yields exactly one result, strobed on
// rsp_valid for one cycle. The pipeline is built from the bit-per-stage units:
// the 97-stage square root, the 87-stage root dividers and the 47-stage distance
// divider, plus three levels of 5-stage multipliers and five single register stages.
// Results cannot be held off, so no request is ever refused after reset.
module unit_cylinder_ray_hit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ucrh_pkg::req_type req_data,
   output logic              rsp_valid,
   output ucrh_pkg::rsp_type rsp_data
);
   localparam int MUL_LAT = 5;
   localparam int SQ_LAT  = 97;
   localparam int RD_LAT  = 87;
   localparam int DD_LAT  = 47;
   localparam int LAT = MUL_LAT + 1 + MUL_LAT + 1 + SQ_LAT + 1 + RD_LAT + MUL_LAT + 1
                        + DD_LAT + 1;
   localparam logic [96:0] ONE64 = {33'd1, 64'd0};

   logic busy_ff;
   logic accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   // side data: {origin_z, dir_z, distance_scale}
   logic signed [95:0] p_dxdx, p_dydy, p_oxdx, p_oydy, p_oxox, p_oyoy;
   logic               m1_valid;
   logic [142:0]       m1_sb;

   ucrh_mul #(.AW(48), .BW(48), .SBW(143)) u_mul_dxdx (
      .clock, .reset, .in_valid(accept), .in_a(req_data.dir_x), .in_b(req_data.dir_x),
      .in_sb({req_data.origin_z, req_data.dir_z, req_data.distance_scale}),
      .out_valid(m1_valid), .out_p(p_dxdx), .out_sb(m1_sb));
   ucrh_mul #(.AW(48), .BW(48), .SBW(1)) u_mul_dydy (
      .clock, .reset, .in_valid(accept), .in_a(req_data.dir_y), .in_b(req_data.dir_y),
      .in_sb(1'b0), .out_valid(), .out_p(p_dydy), .out_sb());
   ucrh_mul #(.AW(48), .BW(48), .SBW(1)) u_mul_oxdx (
      .clock, .reset, .in_valid(accept), .in_a(req_data.origin_x), .in_b(req_data.dir_x),
      .in_sb(1'b0), .out_valid(), .out_p(p_oxdx), .out_sb());
   ucrh_mul #(.AW(48), .BW(48), .SBW(1)) u_mul_oydy (
      .clock, .reset, .in_valid(accept), .in_a(req_data.origin_y), .in_b(req_data.dir_y),
      .in_sb(1'b0), .out_valid(), .out_p(p_oydy), .out_sb());
   ucrh_mul #(.AW(48), .BW(48), .SBW(1)) u_mul_oxox (
      .clock, .reset, .in_valid(accept), .in_a(req_data.origin_x),
      .in_b(req_data.origin_x), .in_sb(1'b0), .out_valid(), .out_p(p_oxox), .out_sb());
   ucrh_mul #(.AW(48), .BW(48), .SBW(1)) u_mul_oyoy (
      .clock, .reset, .in_valid(accept), .in_a(req_data.origin_y),
      .in_b(req_data.origin_y), .in_sb(1'b0), .out_valid(), .out_p(p_oyoy), .out_sb());

   // quadratic coefficients
   logic               s2_valid_ff;
   logic [95:0]        a_ff, a_in;
   logic signed [96:0] b_ff, b_in;
   logic signed [96:0] c_ff, c_in;
   logic               small_ff, small_in;
   logic [142:0]       s2_sb_ff;

   always_comb begin
      a_in     = 96'(p_dxdx) + 96'(p_dydy);
      b_in     = 97'(p_oxdx) + 97'(p_oydy);
      c_in     = 97'(p_oxox) + 97'(p_oyoy) - ONE64;
      small_in = a_in < ucrh_pkg::A_MIN;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= m1_valid;
      end
      a_ff     <= a_in;
      b_ff     <= b_in;
      c_ff     <= c_in;
      small_ff <= small_in;
      s2_sb_ff <= m1_sb;
   end

   // discriminant products
   logic signed [193:0] p_bb, p_ac;
   logic                m3_valid;
   logic [336:0]        m3_sb;

   ucrh_mul #(.AW(97), .BW(97), .SBW(337)) u_mul_bb (
      .clock, .reset, .in_valid(s2_valid_ff), .in_a(b_ff), .in_b(b_ff),
      .in_sb({small_ff, a_ff, b_ff, s2_sb_ff}),
      .out_valid(m3_valid), .out_p(p_bb), .out_sb(m3_sb));
   ucrh_mul #(.AW(97), .BW(97), .SBW(1)) u_mul_ac (
      .clock, .reset, .in_valid(s2_valid_ff), .in_a($signed({1'b0, a_ff})), .in_b(c_ff),
      .in_sb(1'b0), .out_valid(), .out_p(p_ac), .out_sb());

   logic                s4_valid_ff;
   logic signed [194:0] e_val;
   logic                e_ok;
   logic [193:0]        rad_ff, rad_in;
   logic                s4_noh_ff, s4_noh_in;
   logic [335:0]        s4_sb_ff;

   always_comb begin
      e_val     = 195'(p_bb) - 195'(p_ac);
      e_ok      = !e_val[194] && (e_val != '0);
      rad_in    = e_ok ? e_val[193:0] : '0;
      s4_noh_in = m3_sb[336] || !e_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= m3_valid;
      end
      rad_ff    <= rad_in;
      s4_noh_ff <= s4_noh_in;
      s4_sb_ff  <= m3_sb[335:0];
   end

   // square root of the quarter discriminant
   logic         sq_valid;
   logic [96:0]  sq_root;
   logic [336:0] sq_sb;

   ucrh_sqrt #(.EW(194), .SBW(337)) u_sqrt (
      .clock, .reset, .in_valid(s4_valid_ff), .in_rad(rad_ff),
      .in_sb({s4_noh_ff, s4_sb_ff}),
      .out_valid(sq_valid), .out_root(sq_root), .out_sb(sq_sb));

   // root numerators: sq_sb = {noh, a, b, side}
   logic signed [96:0] sq_b;
   logic signed [98:0] n1_val, n2_val;
   logic               s6_valid_ff;
   logic [97:0]        n1_ff, n2_ff;
   logic               pos1_ff, pos1_in, pos2_ff, pos2_in;
   logic [95:0]        s6_a_ff;
   logic               s6_noh_ff;
   logic [142:0]       s6_side_ff;

   always_comb begin
      sq_b    = $signed(sq_sb[239:143]);
      n1_val  = -99'(sq_b) - $signed({2'b00, sq_root});
      n2_val  = -99'(sq_b) + $signed({2'b00, sq_root});
      pos1_in = !n1_val[98] && (n1_val != '0);
      pos2_in = !n2_val[98] && (n2_val != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else begin
         s6_valid_ff <= sq_valid;
      end
      n1_ff      <= n1_val[97:0];
      n2_ff      <= n2_val[97:0];
      pos1_ff    <= pos1_in;
      pos2_ff    <= pos2_in;
      s6_a_ff    <= sq_sb[335:240];
      s6_noh_ff  <= sq_sb[336];
      s6_side_ff <= sq_sb[142:0];
   end

   // root division t = num * 2^32 / a
   logic         d7_valid;
   logic [86:0]  q1, q2;
   logic [145:0] d7_sb;

   ucrh_div #(.NW(130), .DW(96), .QW(87), .SBW(146)) u_div_t1 (
      .clock, .reset, .in_valid(s6_valid_ff), .in_num({n1_ff, 32'd0}), .in_den(s6_a_ff),
      .in_sb({s6_noh_ff, pos1_ff, pos2_ff, s6_side_ff}),
      .out_valid(d7_valid), .out_quo(q1), .out_sb(d7_sb));
   ucrh_div #(.NW(130), .DW(96), .QW(87), .SBW(1)) u_div_t2 (
      .clock, .reset, .in_valid(s6_valid_ff), .in_num({n2_ff, 32'd0}), .in_den(s6_a_ff),
      .in_sb(1'b0), .out_valid(), .out_quo(q2), .out_sb());

   // z at each root: d7_sb = {noh, pos1, pos2, oz, dz, sc}
   logic                ok1, ok2;
   logic signed [135:0] p_tz1, p_tz2;
   logic                m8_valid;
   logic [271:0]        m8_sb;

   assign ok1 = d7_sb[144] && (q1 >= ucrh_pkg::T_MIN);
   assign ok2 = d7_sb[143] && (q2 >= ucrh_pkg::T_MIN);

   ucrh_mul #(.AW(88), .BW(48), .SBW(272)) u_mul_tz1 (
      .clock, .reset, .in_valid(d7_valid), .in_a($signed({1'b0, q1})),
      .in_b($signed(d7_sb[94:47])),
      .in_sb({d7_sb[145], ok1, ok2, q1, q2, d7_sb[142:95], d7_sb[46:0]}),
      .out_valid(m8_valid), .out_p(p_tz1), .out_sb(m8_sb));
   ucrh_mul #(.AW(88), .BW(48), .SBW(1)) u_mul_tz2 (
      .clock, .reset, .in_valid(d7_valid), .in_a($signed({1'b0, q2})),
      .in_b($signed(d7_sb[94:47])), .in_sb(1'b0),
      .out_valid(), .out_p(p_tz2), .out_sb());

   // root choice: m8_sb = {noh, ok1, ok2, t1, t2, oz, sc}
   logic signed [136:0] w1, w2;
   logic                take1, take2;
   logic                s9_valid_ff;
   logic                hit_ff, hit_in;
   logic [86:0]         t_ff, t_in;
   logic [46:0]         sc_ff;
   logic                sat;

   always_comb begin
      w1    = 137'($signed({m8_sb[94:47], 32'd0})) + 137'(p_tz1);
      w2    = 137'($signed({m8_sb[94:47], 32'd0})) + 137'(p_tz2);
      take1 = m8_sb[270] && (w1[136:64] == '0) && (w1[63:0] != '0);
      take2 = m8_sb[269] && (w2[136:64] == '0) && (w2[63:0] != '0);
      hit_in = !m8_sb[271] && (take1 || take2);
      t_in   = take1 ? m8_sb[268:182] : m8_sb[181:95];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s9_valid_ff <= 1'b0;
      end else begin
         s9_valid_ff <= m8_valid;
      end
      hit_ff <= hit_in;
      t_ff   <= t_in;
      sc_ff  <= m8_sb[46:0];
   end

   // distance = t * 2^32 / scale, saturating
   assign sat = (sc_ff == '0) || (t_ff >= {sc_ff, 15'd0});

   logic        d10_valid;
   logic [46:0] dist_q;
   logic [1:0]  d10_sb;

   ucrh_div #(.NW(94), .DW(47), .QW(47), .SBW(2)) u_div_dist (
      .clock, .reset, .in_valid(s9_valid_ff), .in_num({t_ff[61:0], 32'd0}), .in_den(sc_ff),
      .in_sb({hit_ff, sat}), .out_valid(d10_valid), .out_quo(dist_q), .out_sb(d10_sb));

   logic              rsp_valid_ff;
   ucrh_pkg::rsp_type rsp_ff, rsp_in;

   always_comb begin
      rsp_in.hit_found = d10_sb[1];
      if (!d10_sb[1]) begin
         rsp_in.hit_distance = '0;
      end else if (d10_sb[0]) begin
         rsp_in.hit_distance = ucrh_pkg::DIST_MAX;
      end else begin
         rsp_in.hit_distance = dist_q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= d10_valid;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LAT rsp_valid)
      else $error("request lost in pipeline");
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LAT))
      else $error("result without request");
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit_found |-> rsp_data.hit_distance == '0)
      else $error("miss with nonzero distance");
`endif

endmodule

// ===== rtl/ucrh_mul.sv =====
`timescale 1ns / 1ps
// Pipelined signed multiplier built from 32x32 limb products.
module ucrh_mul #(
   parameter int AW  = 48,
   parameter int BW  = 48,
   parameter int SBW = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic signed [AW-1:0]  in_a,
   input  logic signed [BW-1:0]  in_b,
   input  logic [SBW-1:0]        in_sb,
   output logic                  out_valid,
   output logic signed [AW+BW-1:0] out_p,
   output logic [SBW-1:0]        out_sb
);
   localparam int LA  = (AW + 31) / 32;
   localparam int LB  = (BW + 31) / 32;
   localparam int MAW = 32 * LA;
   localparam int MBW = 32 * LB;
   localparam int PW  = AW + BW;
   localparam int RW  = MBW + 32;
   localparam int SW  = MAW + MBW;
   localparam int LAT = 5;

   logic [LAT-1:0]    valid_ff;
   logic [LAT-2:0]    neg_ff;
   logic [SBW-1:0]    sb_ff [LAT];
   logic [AW-1:0]     abs_a;
   logic [BW-1:0]     abs_b;
   logic [MAW-1:0]    mag_a_ff, mag_a_in;
   logic [MBW-1:0]    mag_b_ff, mag_b_in;
   logic [63:0]       pp_ff [LA][LB];
   logic [63:0]       pp_in [LA][LB];
   logic [RW-1:0]     row_ff [LA];
   logic [RW-1:0]     row_in [LA];
   logic [PW-1:0]     sum_ff, sum_in;
   logic signed [PW-1:0] p_ff, p_in;

   always_comb begin
      abs_a = in_a[AW-1] ? (~in_a + AW'(1)) : in_a;
      abs_b = in_b[BW-1] ? (~in_b + BW'(1)) : in_b;
      mag_a_in = MAW'(abs_a);
      mag_b_in = MBW'(abs_b);
   end

   always_comb begin
      for (int i = 0; i < LA; i++) begin
         for (int j = 0; j < LB; j++) begin
            pp_in[i][j] = mag_a_ff[32*i +: 32] * mag_b_ff[32*j +: 32];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < LA; i++) begin
         row_in[i] = '0;
         for (int j = 0; j < LB; j++) begin
            row_in[i] = row_in[i] + (RW'(pp_ff[i][j]) << (32 * j));
         end
      end
   end

   always_comb begin
      logic [SW-1:0] acc;
      acc = '0;
      for (int i = 0; i < LA; i++) begin
         acc = acc + (SW'(row_ff[i]) << (32 * i));
      end
      sum_in = PW'(acc);
   end

   always_comb begin
      p_in = neg_ff[LAT-2] ? $signed(~sum_ff + PW'(1)) : $signed(sum_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[LAT-2:0], in_valid};
      end
      neg_ff   <= {neg_ff[LAT-3:0], in_a[AW-1] ^ in_b[BW-1]};
      sb_ff[0] <= in_sb;
      for (int k = 1; k < LAT; k++) begin
         sb_ff[k] <= sb_ff[k-1];
      end
      mag_a_ff <= mag_a_in;
      mag_b_ff <= mag_b_in;
      pp_ff    <= pp_in;
      row_ff   <= row_in;
      sum_ff   <= sum_in;
      p_ff     <= p_in;
   end

   assign out_valid = valid_ff[LAT-1];
   assign out_p     = p_ff;
   assign out_sb    = sb_ff[LAT-1];

endmodule

// ===== rtl/ucrh_sqrt.sv =====
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage.
module ucrh_sqrt #(
   parameter int EW  = 194,
   parameter int SBW = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [EW-1:0]     in_rad,
   input  logic [SBW-1:0]    in_sb,
   output logic              out_valid,
   output logic [EW/2-1:0]   out_root,
   output logic [SBW-1:0]    out_sb
);
   localparam int N   = EW / 2;
   localparam int RMW = N + 4;

   logic [N-1:0]   valid_ff;
   logic [EW-1:0]  rad_ff [N];
   logic [EW-1:0]  rad_in [N];
   logic [RMW-1:0] rem_ff [N];
   logic [RMW-1:0] rem_in [N];
   logic [N-1:0]   root_ff [N];
   logic [N-1:0]   root_in [N];
   logic [SBW-1:0] sb_ff [N];

   always_comb begin
      logic [EW-1:0]  rad_s;
      logic [RMW-1:0] rem_s;
      logic [RMW-1:0] trial;
      logic [RMW-1:0] test;
      logic [N-1:0]   root_s;
      for (int k = 0; k < N; k++) begin
         if (k == 0) begin
            rad_s  = in_rad;
            rem_s  = '0;
            root_s = '0;
         end else begin
            rad_s  = rad_ff[k-1];
            rem_s  = rem_ff[k-1];
            root_s = root_ff[k-1];
         end
         trial = {rem_s[RMW-3:0], rad_s[EW-1:EW-2]};
         test  = RMW'({root_s, 2'b01});
         if (trial >= test) begin
            rem_in[k]  = trial - test;
            root_in[k] = {root_s[N-2:0], 1'b1};
         end else begin
            rem_in[k]  = trial;
            root_in[k] = {root_s[N-2:0], 1'b0};
         end
         rad_in[k] = rad_s << 2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[N-2:0], in_valid};
      end
      sb_ff[0] <= in_sb;
      for (int k = 1; k < N; k++) begin
         sb_ff[k] <= sb_ff[k-1];
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign out_valid = valid_ff[N-1];
   assign out_root  = root_ff[N-1];
   assign out_sb    = sb_ff[N-1];

endmodule

// ===== rtl/ucrh_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage.
module ucrh_div #(
   parameter int NW  = 130,
   parameter int DW  = 96,
   parameter int QW  = 87,
   parameter int SBW = 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  logic [NW-1:0]   in_num,
   input  logic [DW-1:0]   in_den,
   input  logic [SBW-1:0]  in_sb,
   output logic            out_valid,
   output logic [QW-1:0]   out_quo,
   output logic [SBW-1:0]  out_sb
);
   logic [QW-1:0]  valid_ff;
   logic [DW-1:0]  rem_ff [QW];
   logic [DW-1:0]  rem_in [QW];
   logic [DW-1:0]  den_ff [QW];
   logic [QW-1:0]  lo_ff [QW];
   logic [QW-1:0]  lo_in [QW];
   logic [SBW-1:0] sb_ff [QW];

   always_comb begin
      logic [DW-1:0] rem_s;
      logic [DW-1:0] den_s;
      logic [QW-1:0] lo_s;
      logic [DW:0]   trial;
      for (int k = 0; k < QW; k++) begin
         if (k == 0) begin
            rem_s = DW'(in_num[NW-1:QW]);
            den_s = in_den;
            lo_s  = in_num[QW-1:0];
         end else begin
            rem_s = rem_ff[k-1];
            den_s = den_ff[k-1];
            lo_s  = lo_ff[k-1];
         end
         trial = {rem_s, lo_s[QW-1]};
         if (trial >= {1'b0, den_s}) begin
            rem_in[k] = DW'(trial - {1'b0, den_s});
            lo_in[k]  = {lo_s[QW-2:0], 1'b1};
         end else begin
            rem_in[k] = trial[DW-1:0];
            lo_in[k]  = {lo_s[QW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[QW-2:0], in_valid};
      end
      sb_ff[0]  <= in_sb;
      den_ff[0] <= in_den;
      for (int k = 1; k < QW; k++) begin
         sb_ff[k]  <= sb_ff[k-1];
         den_ff[k] <= den_ff[k-1];
      end
      rem_ff <= rem_in;
      lo_ff  <= lo_in;
   end

   assign out_valid = valid_ff[QW-1];
   assign out_quo   = lo_ff[QW-1];
   assign out_sb    = sb_ff[QW-1];

endmodule
